// ----- rtl/core/dual_lehmer_generator_match_counter_unit_assert.svh -----
// Assertion macros shared by the generator pair RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef DUAL_LEHMER_GENERATOR_MATCH_COUNTER_UNIT_ASSERT_SVH
`define DUAL_LEHMER_GENERATOR_MATCH_COUNTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define DLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DLG_ASSERT_IMP(lbl, ante, cons, msg)
`define DLG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/dlg_pkg.sv -----
// Shared widths, constants and register indexes of the generator pair.
// No dependencies.
package dlg_pkg;

  localparam int GEN_W      = 31;
  localparam int CRIT_W     = 8;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TRIES_W    = 17;
  localparam int MATCH_BITS_DEF = 16;

  localparam logic [GEN_W-1:0]   LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [TRIES_W-1:0] MAX_TRIES  = 17'd65536;

  localparam logic [GEN_W-1:0]  FACTOR_A_RST = 31'd16807;
  localparam logic [GEN_W-1:0]  FACTOR_B_RST = 31'd48271;
  localparam logic [CRIT_W-1:0] CRIT_RST     = 8'd1;
  localparam logic [GEN_W-1:0]  SEED_A_RST   = 31'd65;
  localparam logic [GEN_W-1:0]  SEED_B_RST   = 31'd8921;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_B   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_B   = 3'd5;

endpackage

// ----- rtl/core/dual_lehmer_generator_match_counter_unit.sv -----
// Pair of Lehmer generators modulo 2^31-1 with a low-bit match counter.
// Depends on dlg_pkg, dlg_mulmod, dlg_rem and the assertion header.
//
// One step request runs generator A, then generator B, through a single shared
// multiply-and-reduce unit with a product stage and a fold stage. When the
// generator's criterion is above 1, a remainder test follows each multiply
// and multiplying repeats until the remainder is zero; each generator stops
// after 65536 multiplications. The result sits in an output register, so the
// next step is taken while it waits to be read; a step that finishes while
// the previous result is still unread holds until it is. Configuration
// registers are to be written only while no step is in progress; the user
// is bound by this, as the block itself does not enforce it.
`include "dual_lehmer_generator_match_counter_unit_assert.svh"

module dual_lehmer_generator_match_counter_unit #(
  parameter int MATCH_BITS = dlg_pkg::MATCH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dlg_pkg::GEN_W-1:0]     out_value_a,
  output logic [dlg_pkg::GEN_W-1:0]     out_value_b,
  output logic                          out_matched,
  output logic [dlg_pkg::CNT_W-1:0]     out_match_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dlg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [GEN_W-1:0] MatchMask = {GEN_W{1'b1}} >> (GEN_W - MATCH_BITS);

  logic [GEN_W-1:0]  factor_a_r, factor_b_r, seed_a_r, seed_b_r;
  logic [CRIT_W-1:0] crit_a_r, crit_b_r;

  logic [1:0]         state_r, state_nxt;
  logic               sel_r, sel_nxt;
  logic [TRIES_W-1:0] tries_r, tries_nxt;
  logic [GEN_W-1:0]   gen_a_r, gen_a_nxt, gen_b_r, gen_b_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [GEN_W-1:0]   out_value_a_r, out_value_b_r;
  logic               out_matched_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               in_fire, out_fire, out_load, gen_finish, hit;
  logic [GEN_W-1:0]   cur_gen, cur_fac;
  logic [CRIT_W-1:0]  cur_crit;
  logic               mm_start, mm_done, rem_start, rem_done, rem_zero;
  logic [GEN_W-1:0]   mm_op, mm_fac, mm_res;

  dlg_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .op_a   (mm_op),
    .op_b   (mm_fac),
    .done   (mm_done),
    .result (mm_res)
  );

  dlg_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (mm_res),
    .divisor  (cur_crit),
    .done     (rem_done),
    .is_zero  (rem_zero)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  assign cur_gen  = sel_r ? gen_b_r : gen_a_r;
  assign cur_fac  = sel_r ? factor_b_r : factor_a_r;
  assign cur_crit = sel_r ? crit_b_r : crit_a_r;
  assign hit      = ((gen_a_r & MatchMask) == (gen_b_r & MatchMask));

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    tries_nxt  = tries_r;
    gen_a_nxt  = gen_a_r;
    gen_b_nxt  = gen_b_r;
    total_nxt  = total_r;
    mm_start   = 1'b0;
    mm_op      = cur_gen;
    mm_fac     = cur_fac;
    rem_start  = 1'b0;
    gen_finish = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sel_nxt   = 1'b0;
          tries_nxt = '0;
          mm_fac    = factor_a_r;
          mm_op     = in_restart ? seed_a_r : gen_a_r;
          mm_start  = 1'b1;
          state_nxt = S_MUL;
          if (in_restart) begin
            gen_a_nxt = seed_a_r;
            gen_b_nxt = seed_b_r;
            total_nxt = '0;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          tries_nxt = tries_r + TRIES_W'(1);
          if (sel_r) begin
            gen_b_nxt = mm_res;
          end else begin
            gen_a_nxt = mm_res;
          end
          if (cur_crit < CRIT_W'(2)) begin
            gen_finish = 1'b1;
          end else begin
            rem_start = 1'b1;
            state_nxt = S_REM;
          end
        end
      end
      S_REM: begin
        if (rem_done) begin
          if (rem_zero || (tries_r == MAX_TRIES)) begin
            gen_finish = 1'b1;
          end else begin
            mm_start  = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (hit && (total_r != {CNT_W{1'b1}})) begin
            total_nxt = total_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (gen_finish) begin
      if (!sel_r) begin
        sel_nxt   = 1'b1;
        tries_nxt = '0;
        mm_op     = gen_b_r;
        mm_fac    = factor_b_r;
        mm_start  = 1'b1;
        state_nxt = S_MUL;
      end else begin
        state_nxt = S_OUT;
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      tries_r     <= '0;
      gen_a_r     <= SEED_A_RST;
      gen_b_r     <= SEED_B_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      factor_a_r  <= FACTOR_A_RST;
      factor_b_r  <= FACTOR_B_RST;
      crit_a_r    <= CRIT_RST;
      crit_b_r    <= CRIT_RST;
      seed_a_r    <= SEED_A_RST;
      seed_b_r    <= SEED_B_RST;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      tries_r     <= tries_nxt;
      gen_a_r     <= gen_a_nxt;
      gen_b_r     <= gen_b_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FACTOR_A: factor_a_r <= cfg_data[GEN_W-1:0];
          REG_FACTOR_B: factor_b_r <= cfg_data[GEN_W-1:0];
          REG_CRIT_A:   crit_a_r   <= cfg_data[CRIT_W-1:0];
          REG_CRIT_B:   crit_b_r   <= cfg_data[CRIT_W-1:0];
          REG_SEED_A:   seed_a_r   <= cfg_data[GEN_W-1:0];
          REG_SEED_B:   seed_b_r   <= cfg_data[GEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_a_r <= gen_a_r;
      out_value_b_r <= gen_b_r;
      out_matched_r <= hit;
      out_count_r   <= total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_a     = out_value_a_r;
  assign out_value_b     = out_value_b_r;
  assign out_matched     = out_matched_r;
  assign out_match_count = out_count_r;

  `DLG_ASSERT_IMP(a_mm_done_in_mul, mm_done, state_r == S_MUL, "multiply result outside S_MUL")
  `DLG_ASSERT_IMP(a_rem_done_in_rem, rem_done, state_r == S_REM, "remainder result outside S_REM")
  `DLG_ASSERT_IMP(a_tries_bound, state_r != S_IDLE, tries_r <= MAX_TRIES, "try count overrun")
  `DLG_ASSERT_IMP(a_match_counted, out_valid_r && out_matched_r, out_count_r != '0, "match not counted")
  `DLG_ASSERT_NXT(a_load_sets_valid, out_load, out_valid_r, "result register not loaded")

endmodule

// ----- rtl/core/dlg_mulmod.sv -----
// Shared multiply and reduce modulo 2^31-1: product stage, then fold stage.
// Depends on dlg_pkg.
module dlg_mulmod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dlg_pkg::GEN_W-1:0] op_a,
  input  logic [dlg_pkg::GEN_W-1:0] op_b,
  output logic                      done,
  output logic [dlg_pkg::GEN_W-1:0] result
);
  import dlg_pkg::*;

  logic [2*GEN_W-1:0] prod_r;
  logic               p1_r;
  logic               p2_r;
  logic [GEN_W-1:0]   res_r;
  logic [GEN_W:0]     sum;
  logic [GEN_W:0]     fold;
  logic [GEN_W-1:0]   res_nxt;

  always_comb begin
    sum  = {1'b0, prod_r[2*GEN_W-1:GEN_W]} + {1'b0, prod_r[GEN_W-1:0]};
    fold = {1'b0, sum[GEN_W-1:0]} + {{GEN_W{1'b0}}, sum[GEN_W]};
    if (fold >= {1'b0, LEHMER_MOD}) begin
      res_nxt = GEN_W'(fold - {1'b0, LEHMER_MOD});
    end else begin
      res_nxt = fold[GEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else begin
      p1_r <= start;
      p2_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= op_a * op_b;
    end
    if (p1_r) begin
      res_r <= res_nxt;
    end
  end

  assign done   = p2_r;
  assign result = res_r;

endmodule

// ----- rtl/core/dlg_rem.sv -----
// Remainder test of a 31-bit value by an 8-bit divisor, eight bits per cycle.
// Depends on dlg_pkg.
module dlg_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dlg_pkg::GEN_W-1:0]  dividend,
  input  logic [dlg_pkg::CRIT_W-1:0] divisor,
  output logic                       done,
  output logic                       is_zero
);
  import dlg_pkg::*;

  logic [GEN_W:0]      sh_r;
  logic [CRIT_W-1:0]   div_r;
  logic [CRIT_W-1:0]   rem_r;
  logic [1:0]          cnt_r;
  logic                run_r;
  logic                done_r;

  function automatic logic [CRIT_W-1:0] rem_step8(
    input logic [CRIT_W-1:0] r,
    input logic [7:0]        bits,
    input logic [CRIT_W-1:0] d
  );
    logic [CRIT_W:0]   t;
    logic [CRIT_W-1:0] acc;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[CRIT_W-1:0];
    end
    return acc;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= {1'b0, dividend};
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      sh_r  <= {sh_r[GEN_W-8:0], 8'd0};
      rem_r <= rem_step8(rem_r, sh_r[GEN_W:GEN_W-7], div_r);
    end
  end

  assign done    = done_r;
  assign is_zero = (rem_r == '0);

endmodule

// ----- bench/tb.sv -----
// Testbench for the dual Lehmer generator pair and its low-bit match counter.
// Sends step requests and register writes over valid/ready channels and checks each result
// against an in-bench model of both generators. Depends on dlg_pkg and the generator RTL.
module tb;
  import dlg_pkg::*;

  localparam int MATCH_W = MATCH_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [GEN_W-1:0] value_a;
    logic [GEN_W-1:0] value_b;
    logic             matched;
    logic [CNT_W-1:0] match_count;
  } draw_t;

  typedef struct {
    logic [GEN_W-1:0]  factor_a;
    logic [GEN_W-1:0]  factor_b;
    logic [CRIT_W-1:0] crit_a;
    logic [CRIT_W-1:0] crit_b;
    logic [GEN_W-1:0]  seed_a;
    logic [GEN_W-1:0]  seed_b;
  } gen_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [GEN_W-1:0]      out_value_a;
  logic [GEN_W-1:0]      out_value_b;
  logic                  out_matched;
  logic [CNT_W-1:0]      out_match_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gen_cfg_t         shadow_cfg;
  logic [GEN_W-1:0] gen_a_now;
  logic [GEN_W-1:0] gen_b_now;
  logic [CNT_W-1:0] hits_total;
  draw_t            draws_due[$];

  int errors = 0;
  int steps_sent = 0;
  int restarts_sent = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int settings_loaded = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold = 0;

  dual_lehmer_generator_match_counter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value_a     (out_value_a),
    .out_value_b     (out_value_b),
    .out_matched     (out_matched),
    .out_match_count (out_match_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [GEN_W-1:0] lehmer_walk(logic [GEN_W-1:0] start,
                                                   logic [GEN_W-1:0] factor,
                                                   logic [CRIT_W-1:0] crit);
    logic [63:0]      prod;
    logic [GEN_W-1:0] v;
    int unsigned      modulus;
    v = start;
    modulus = (crit == '0) ? 32'd1 : 32'(crit);
    for (int n = 0; n < int'(MAX_TRIES); n++) begin
      prod = {33'd0, v} * {33'd0, factor};
      v = GEN_W'(prod % {33'd0, LEHMER_MOD});
      if ({1'b0, v} % modulus == 0) break;
    end
    return v;
  endfunction

  function automatic draw_t predict_draw(logic restart);
    draw_t d;
    if (restart) begin
      gen_a_now = shadow_cfg.seed_a;
      gen_b_now = shadow_cfg.seed_b;
      hits_total = '0;
    end
    gen_a_now = lehmer_walk(gen_a_now, shadow_cfg.factor_a, shadow_cfg.crit_a);
    gen_b_now = lehmer_walk(gen_b_now, shadow_cfg.factor_b, shadow_cfg.crit_b);
    d.matched = gen_a_now[MATCH_W-1:0] == gen_b_now[MATCH_W-1:0];
    if (d.matched && hits_total != '1) hits_total++;
    d.value_a = gen_a_now;
    d.value_b = gen_b_now;
    d.match_count = hits_total;
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CRIT_W-1:0] pick_criterion(bit wide);
    if (wide) return CRIT_W'($urandom_range(255, 9));
    return CRIT_W'($urandom_range(8, 0));
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s, result %0d: got %0d, expected %0d",
               field, results_seen, got, want);
  endtask

  task automatic send_step(logic restart);
    int gap;
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    draws_due.push_back(predict_draw(restart));
    steps_sent++;
    if (restart) restarts_sent++;
    gap = ($urandom_range(99) < src_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (draws_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FACTOR_A: shadow_cfg.factor_a = data[GEN_W-1:0];
      REG_FACTOR_B: shadow_cfg.factor_b = data[GEN_W-1:0];
      REG_CRIT_A:   shadow_cfg.crit_a = data[CRIT_W-1:0];
      REG_CRIT_B:   shadow_cfg.crit_b = data[CRIT_W-1:0];
      REG_SEED_A:   shadow_cfg.seed_a = data[GEN_W-1:0];
      REG_SEED_B:   shadow_cfg.seed_b = data[GEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(gen_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = $urandom();
    write_reg(REG_FACTOR_A, {junk[31], c.factor_a});
    write_reg(REG_FACTOR_B, {junk[30], c.factor_b});
    write_reg(REG_CRIT_A, {junk[31:8], c.crit_a});
    write_reg(REG_CRIT_B, {junk[23:0], c.crit_b});
    write_reg(REG_SEED_A, {junk[29], c.seed_a});
    write_reg(REG_SEED_B, {junk[28], c.seed_b});
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic test_reset_defaults();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_criteria();
    gen_cfg_t c;
    c = shadow_cfg;
    c.crit_a = '0;
    c.crit_b = 8'd255;
    load_config(c);
    src_idle_pct = 50;
    sink_stall_pct = 50;
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    c.crit_a = 8'd4;
    c.crit_b = 8'd8;
    load_config(c);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_zero_values();
    gen_cfg_t c;
    c = shadow_cfg;
    c.seed_a = LEHMER_MOD;
    c.factor_a = FACTOR_A_RST;
    c.factor_b = '0;
    c.crit_a = 8'd3;
    c.crit_b = 8'd5;
    load_config(c);
    send_step(1'b1);
    send_step(1'b0);
    c.factor_a = LEHMER_MOD;
    c.seed_a = 31'd1;
    c.factor_b = LEHMER_MOD - 31'd1;
    c.seed_b = 31'd1;
    c.crit_b = 8'd1;
    load_config(c);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_low_bit_match();
    gen_cfg_t c;
    c.factor_a = 31'd1;
    c.factor_b = 31'd1;
    c.crit_a = 8'd1;
    c.crit_b = 8'd1;
    c.seed_a = 31'h1234_5678;
    c.seed_b = 31'h5234_5678;
    load_config(c);
    sink_stall_pct = 0;
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_endless_filter();
    gen_cfg_t c;
    c.factor_a = 31'd1;
    c.factor_b = FACTOR_B_RST;
    c.crit_a = 8'd2;
    c.crit_b = 8'd1;
    c.seed_a = 31'd7;
    c.seed_b = SEED_B_RST;
    load_config(c);
    send_step(1'b1);
  endtask

  task automatic test_stray_index();
    settle();
    write_reg(REG_SPARE_6, $urandom());
    write_reg(REG_SPARE_7, $urandom());
    cfg_valid <= 1'b0;
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_random_phases();
    gen_cfg_t c;
    bit       wide;
    int       burst;
    for (int ph = 0; ph < 7; ph++) begin
      wide = (ph == 3);
      c.factor_a = GEN_W'($urandom_range(LEHMER_MOD - 1, 1));
      c.factor_b = GEN_W'($urandom_range(LEHMER_MOD - 1, 1));
      c.seed_a = GEN_W'($urandom_range(LEHMER_MOD - 1, 1));
      c.seed_b = GEN_W'($urandom_range(LEHMER_MOD - 1, 1));
      c.crit_a = pick_criterion(wide);
      c.crit_b = pick_criterion(wide);
      if ($urandom_range(99) < 30) begin
        c.factor_b = c.factor_a;
        c.seed_b = c.seed_a;
        c.crit_b = c.crit_a;
      end
      load_config(c);
      if (ph == 0) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_idle_pct = $urandom_range(60, 5);
        sink_stall_pct = $urandom_range(60, 5);
      end
      burst = wide ? 20 : 95;
      for (int k = 0; k < burst; k++)
        send_step(k == 0 || $urandom_range(99) < 8);
    end
  endtask

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < sink_stall_pct) begin
      sink_hold = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    draw_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (draws_due.size() == 0) begin
        report_mismatch("unrequested result", 64'(out_value_a), '0);
      end else begin
        want = draws_due.pop_front();
        if (out_value_a !== want.value_a)
          report_mismatch("value_a", 64'(out_value_a), 64'(want.value_a));
        if (out_value_b !== want.value_b)
          report_mismatch("value_b", 64'(out_value_b), 64'(want.value_b));
        if (out_matched !== want.matched)
          report_mismatch("matched", 64'(out_matched), 64'(want.matched));
        if (out_match_count !== want.match_count)
          report_mismatch("match_count", 64'(out_match_count), 64'(want.match_count));
        if (out_matched === 1'b1) matches_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, draws_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    shadow_cfg.factor_a = FACTOR_A_RST;
    shadow_cfg.factor_b = FACTOR_B_RST;
    shadow_cfg.crit_a = CRIT_RST;
    shadow_cfg.crit_b = CRIT_RST;
    shadow_cfg.seed_a = SEED_A_RST;
    shadow_cfg.seed_b = SEED_B_RST;
    gen_a_now = SEED_A_RST;
    gen_b_now = SEED_B_RST;
    hits_total = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_criteria();
    test_zero_values();
    test_low_bit_match();
    test_endless_filter();
    test_stray_index();
    test_random_phases();
    settle();
    $display("Checked %0d steps (%0d with restart) over %0d register settings, %0d matches.",
             steps_sent, restarts_sent, settings_loaded, matches_seen);
    $display("Covered criterion 0 and 255, zero-valued generators, a filter that never hits,");
    $display("spare register indexes and random stalls on both channels.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
